FILE: design/qrs_pkg.sv
`default_nettype none
package qrs_pkg;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOREAL = 2'd1,
    ST_AZERO  = 2'd2,
    ST_SAT    = 2'd3
  } qrs_status_t;

  // handshake state of one pipeline cell
  typedef struct packed {
    logic en;
    logic vld;
  } qrs_ctl_t;

endpackage
`default_nettype wire

FILE: design/qrs_sqrt_cell.sv
`default_nettype none
// One bit of the integer square root: decides root bit K.
module qrs_sqrt_cell
  import qrs_pkg::*;
#(
  parameter int DW  = 65,
  parameter int SW  = 33,
  parameter int K   = 0,
  parameter int SBW = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire qrs_ctl_t       ctl_i,
  input  wire logic [DW-1:0]  rem_i,
  input  wire logic [SW-1:0]  root_i,
  input  wire logic [SBW-1:0] sb_i,
  output logic                vld_o,
  output logic [DW-1:0]       rem_o,
  output logic [SW-1:0]       root_o,
  output logic [SBW-1:0]      sb_o
);

  localparam int TW = DW + SW + 1;

  logic [TW-1:0]  trial;
  logic [TW-1:0]  rem_ext;
  logic           fit;
  logic           vld_r;
  logic [DW-1:0]  rem_r, rem_nxt;
  logic [SW-1:0]  root_r, root_nxt;
  logic [SBW-1:0] sb_r;

  // (2r + 2^K) * 2^K, r holding only bits above K
  assign trial   = ({{(TW-SW){1'b0}}, root_i} << (K + 1)) | ({{(TW-1){1'b0}}, 1'b1} << (2 * K));
  assign rem_ext = {{(TW-DW){1'b0}}, rem_i};
  assign fit     = rem_ext >= trial;

  always_comb begin
    rem_nxt  = rem_i;
    root_nxt = root_i;
    if (fit) begin
      rem_nxt  = DW'(rem_ext - trial);
      root_nxt = root_i | ({{(SW-1){1'b0}}, 1'b1} << K);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl_i.en) begin
      vld_r <= ctl_i.vld;
    end
    if (ctl_i.en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      sb_r   <= sb_i;
    end
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign sb_o   = sb_r;

endmodule
`default_nettype wire

FILE: design/qrs_div_cell.sv
`default_nettype none
// One quotient bit of two restoring divisions running side by side.
module qrs_div_cell
  import qrs_pkg::*;
#(
  parameter int NW  = 52,
  parameter int DNW = 35,
  parameter int QW  = 32,
  parameter int I   = 0,
  parameter int SBW = 7
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire qrs_ctl_t       ctl_i,
  input  wire logic [NW-1:0]  rem0_i,
  input  wire logic [NW-1:0]  rem1_i,
  input  wire logic [DNW-1:0] dn0_i,
  input  wire logic [DNW-1:0] dn1_i,
  input  wire logic [QW-1:0]  q0_i,
  input  wire logic [QW-1:0]  q1_i,
  input  wire logic [SBW-1:0] sb_i,
  output logic                vld_o,
  output logic [NW-1:0]       rem0_o,
  output logic [NW-1:0]       rem1_o,
  output logic [DNW-1:0]      dn0_o,
  output logic [DNW-1:0]      dn1_o,
  output logic [QW-1:0]       q0_o,
  output logic [QW-1:0]       q1_o,
  output logic [SBW-1:0]      sb_o
);

  localparam int XW = NW + QW;

  logic [XW-1:0]  trial0, trial1, ext0, ext1;
  logic           fit0, fit1;
  logic           vld_r;
  logic [NW-1:0]  rem0_r, rem0_nxt, rem1_r, rem1_nxt;
  logic [DNW-1:0] dn0_r, dn1_r;
  logic [QW-1:0]  q0_r, q0_nxt, q1_r, q1_nxt;
  logic [SBW-1:0] sb_r;

  assign trial0 = {{(XW-DNW){1'b0}}, dn0_i} << I;
  assign trial1 = {{(XW-DNW){1'b0}}, dn1_i} << I;
  assign ext0   = {{QW{1'b0}}, rem0_i};
  assign ext1   = {{QW{1'b0}}, rem1_i};
  assign fit0   = ext0 >= trial0;
  assign fit1   = ext1 >= trial1;

  always_comb begin
    rem0_nxt = fit0 ? NW'(ext0 - trial0) : rem0_i;
    rem1_nxt = fit1 ? NW'(ext1 - trial1) : rem1_i;
    q0_nxt   = q0_i | ({{(QW-1){1'b0}}, fit0} << I);
    q1_nxt   = q1_i | ({{(QW-1){1'b0}}, fit1} << I);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl_i.en) begin
      vld_r <= ctl_i.vld;
    end
    if (ctl_i.en) begin
      rem0_r <= rem0_nxt;
      rem1_r <= rem1_nxt;
      dn0_r  <= dn0_i;
      dn1_r  <= dn1_i;
      q0_r   <= q0_nxt;
      q1_r   <= q1_nxt;
      sb_r   <= sb_i;
    end
  end

  assign vld_o  = vld_r;
  assign rem0_o = rem0_r;
  assign rem1_o = rem1_r;
  assign dn0_o  = dn0_r;
  assign dn1_o  = dn1_r;
  assign q0_o   = q0_r;
  assign q1_o   = q1_r;
  assign sb_o   = sb_r;

endmodule
`default_nettype wire

FILE: design/quadratic_real_root_solver_top.sv
// channel | direction | ports                                    | handshake
// in      | in        | in_coef_a, in_coef_b, in_coef_c          | in_valid / in_ready
// out     | out       | out_root_low, out_root_high, out_status  | out_valid / out_ready
//
// One item per cycle sustained while the output register is empty or being taken.
// Latency is set by the square-root cell row (WORD_WIDTH+1 cells) and the divider
// cell row (WORD_WIDTH cells), plus decode, multiply, discriminant, sum, range check
// and output stages. Synchronous reset clears the valid bits only.
// A stall on out freezes the whole row; in_ready follows out_ready and the output
// register, so a new item enters whenever the output is empty or being taken.
`default_nettype none
module quadratic_real_root_solver_top
  import qrs_pkg::*;
#(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [WORD_WIDTH-1:0] in_coef_a,
  input  wire logic signed [WORD_WIDTH-1:0] in_coef_b,
  input  wire logic signed [WORD_WIDTH-1:0] in_coef_c,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [WORD_WIDTH-1:0]      out_root_low,
  output logic signed [WORD_WIDTH-1:0]      out_root_high,
  output logic [1:0]                        out_status
);

  localparam int W     = WORD_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int DW    = 2 * W + 1;
  localparam int SW    = W + 1;
  localparam int TW    = W + 2;
  localparam int NW    = W + F + 4;
  localparam int DNW   = W + 3;
  localparam int SQSB  = 3 * W + 4;
  localparam int DVSB  = 7;

  logic en;

  // stage 1: magnitudes and signs
  logic         v1_r;
  logic         sa1_r, sb1_r, sc1_r;
  logic [W-1:0] ma1_r, mb1_r, mc1_r;
  logic [W-1:0] ua, ub, uc;

  // stage 2: products
  logic           v2_r;
  logic           sa2_r, sb2_r, sc2_r;
  logic [W-1:0]   ma2_r, mb2_r, mc2_r;
  logic [2*W-1:0] p2_r, ac2_r;

  // stage 3: discriminant
  logic              v3_r;
  logic [DW-1:0]     d3_r, d3_nxt;
  logic [DW-1:0]     pw, rw;
  qrs_status_t       st3_r, st3_nxt;
  logic              neg0_3_r, neg1_3_r, bpos2;
  logic [W-1:0]      ma3_r, mb3_r, mc3_r;

  // square-root row
  logic          sq_vld [SW+1];
  logic [DW-1:0] sq_rem [SW+1];
  logic [SW-1:0] sq_root[SW+1];
  logic [SQSB-1:0] sq_sb[SW+1];

  // stage 4: sum and dividends
  logic [W-1:0]   ma_s, mb_s, mc_s;
  logic [1:0]     st_s;
  logic           neg0_s, neg1_s;
  logic [TW-1:0]  t_s;
  logic           v4_r, v5_r;
  logic [NW-1:0]  n0_4_r, n1_4_r, n0_5_r, n1_5_r;
  logic [DNW-1:0] dn0_4_r, dn1_4_r, dn0_5_r, dn1_5_r;
  logic [1:0]     st4_r, st5_r;
  logic           neg0_4_r, neg1_4_r, dbl4_r;
  logic           neg0_5_r, neg1_5_r, dbl5_r, ovf0_5_r, ovf1_5_r;

  // divider row
  logic           dv_vld [W+1];
  logic [NW-1:0]  dv_rem0[W+1];
  logic [NW-1:0]  dv_rem1[W+1];
  logic [DNW-1:0] dv_dn0 [W+1];
  logic [DNW-1:0] dv_dn1 [W+1];
  logic [W-1:0]   dv_q0  [W+1];
  logic [W-1:0]   dv_q1  [W+1];
  logic [DVSB-1:0] dv_sb [W+1];

  // output
  logic           out_valid_r;
  logic [W-1:0]   lo_r, lo_nxt, hi_r, hi_nxt;
  qrs_status_t    st_out_r, st_out_nxt;
  logic [1:0]     st_f;
  logic           neg0_f, neg1_f, dbl_f, ovf0_f, ovf1_f, sat0, sat1;
  logic [W-1:0]   lim0, lim1, val0, val1;

  localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  assign ua = in_coef_a;
  assign ub = in_coef_b;
  assign uc = in_coef_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= sq_vld[SW];
      v5_r <= v4_r;
      out_valid_r <= dv_vld[W];
    end
  end

  // decode and multiply
  always_ff @(posedge clk) begin
    if (en) begin
      sa1_r <= ua[W-1];
      sb1_r <= ub[W-1];
      sc1_r <= uc[W-1];
      ma1_r <= ua[W-1] ? (~ua + 1'b1) : ua;
      mb1_r <= ub[W-1] ? (~ub + 1'b1) : ub;
      mc1_r <= uc[W-1] ? (~uc + 1'b1) : uc;
      sa2_r <= sa1_r;
      sb2_r <= sb1_r;
      sc2_r <= sc1_r;
      ma2_r <= ma1_r;
      mb2_r <= mb1_r;
      mc2_r <= mc1_r;
      p2_r  <= mb1_r * mb1_r;
      ac2_r <= ma1_r * mc1_r;
    end
  end

  assign pw    = {1'b0, p2_r};
  assign rw    = DW'({ac2_r, 2'b00});
  assign bpos2 = !sb2_r && (mb2_r != '0);

  always_comb begin
    st3_nxt = ST_OK;
    d3_nxt  = '0;
    priority if (ma2_r == '0) begin
      st3_nxt = ST_AZERO;
    end else if (sa2_r != sc2_r && mc2_r != '0) begin
      d3_nxt = pw + rw;
    end else if (pw < rw) begin
      st3_nxt = ST_NOREAL;
    end else begin
      d3_nxt = pw - rw;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d3_r     <= d3_nxt;
      st3_r    <= st3_nxt;
      neg0_3_r <= bpos2 != sa2_r;
      neg1_3_r <= (!sc2_r && mc2_r != '0) != !bpos2;
      ma3_r    <= ma2_r;
      mb3_r    <= mb2_r;
      mc3_r    <= mc2_r;
    end
  end

  assign sq_vld[0]  = v3_r;
  assign sq_rem[0]  = d3_r;
  assign sq_root[0] = '0;
  assign sq_sb[0]   = {mb3_r, ma3_r, mc3_r, st3_r, neg0_3_r, neg1_3_r};

  for (genvar j = 0; j < SW; j++) begin : g_sqrt
    qrs_ctl_t ctl;
    assign ctl.en  = en;
    assign ctl.vld = sq_vld[j];
    qrs_sqrt_cell #(.DW(DW), .SW(SW), .K(SW - 1 - j), .SBW(SQSB)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (ctl),
      .rem_i  (sq_rem[j]),
      .root_i (sq_root[j]),
      .sb_i   (sq_sb[j]),
      .vld_o  (sq_vld[j+1]),
      .rem_o  (sq_rem[j+1]),
      .root_o (sq_root[j+1]),
      .sb_o   (sq_sb[j+1])
    );
  end

  assign {mb_s, ma_s, mc_s, st_s, neg0_s, neg1_s} = sq_sb[SW];
  assign t_s = {1'b0, sq_root[SW]} + {2'b00, mb_s};

  // rounded quotient: floor((2n + d) / 2d)
  always_ff @(posedge clk) begin
    if (en) begin
      n0_4_r   <= NW'({t_s, {(F+1){1'b0}}}) + NW'({ma_s, 1'b0});
      dn0_4_r  <= DNW'({ma_s, 2'b00});
      n1_4_r   <= NW'({mc_s, {(F+2){1'b0}}}) + NW'(t_s);
      dn1_4_r  <= DNW'({t_s, 1'b0});
      st4_r    <= st_s;
      neg0_4_r <= neg0_s;
      neg1_4_r <= neg1_s;
      dbl4_r   <= sq_root[SW] == '0;
      n0_5_r   <= n0_4_r;
      n1_5_r   <= n1_4_r;
      dn0_5_r  <= dn0_4_r;
      dn1_5_r  <= dn1_4_r;
      st5_r    <= st4_r;
      neg0_5_r <= neg0_4_r;
      neg1_5_r <= neg1_4_r;
      dbl5_r   <= dbl4_r;
      ovf0_5_r <= (n0_4_r >> W) >= {{(NW-DNW){1'b0}}, dn0_4_r};
      ovf1_5_r <= (n1_4_r >> W) >= {{(NW-DNW){1'b0}}, dn1_4_r};
    end
  end

  assign dv_vld[0]  = v5_r;
  assign dv_rem0[0] = n0_5_r;
  assign dv_rem1[0] = n1_5_r;
  assign dv_dn0[0]  = dn0_5_r;
  assign dv_dn1[0]  = dn1_5_r;
  assign dv_q0[0]   = '0;
  assign dv_q1[0]   = '0;
  assign dv_sb[0]   = {st5_r, neg0_5_r, neg1_5_r, dbl5_r, ovf0_5_r, ovf1_5_r};

  for (genvar j = 0; j < W; j++) begin : g_div
    qrs_ctl_t ctl;
    assign ctl.en  = en;
    assign ctl.vld = dv_vld[j];
    qrs_div_cell #(.NW(NW), .DNW(DNW), .QW(W), .I(W - 1 - j), .SBW(DVSB)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (ctl),
      .rem0_i (dv_rem0[j]),
      .rem1_i (dv_rem1[j]),
      .dn0_i  (dv_dn0[j]),
      .dn1_i  (dv_dn1[j]),
      .q0_i   (dv_q0[j]),
      .q1_i   (dv_q1[j]),
      .sb_i   (dv_sb[j]),
      .vld_o  (dv_vld[j+1]),
      .rem0_o (dv_rem0[j+1]),
      .rem1_o (dv_rem1[j+1]),
      .dn0_o  (dv_dn0[j+1]),
      .dn1_o  (dv_dn1[j+1]),
      .q0_o   (dv_q0[j+1]),
      .q1_o   (dv_q1[j+1]),
      .sb_o   (dv_sb[j+1])
    );
  end

  assign {st_f, neg0_f, neg1_f, dbl_f, ovf0_f, ovf1_f} = dv_sb[W];

  assign lim0 = neg0_f ? HALF : HALF - 1'b1;
  assign lim1 = neg1_f ? HALF : HALF - 1'b1;
  assign sat0 = ovf0_f || (dv_q0[W] > lim0);
  assign sat1 = ovf1_f || (dv_q1[W] > lim1);
  assign val0 = sat0 ? (neg0_f ? HALF : HALF - 1'b1)
                     : (neg0_f ? (~dv_q0[W] + 1'b1) : dv_q0[W]);
  assign val1 = sat1 ? (neg1_f ? HALF : HALF - 1'b1)
                     : (neg1_f ? (~dv_q1[W] + 1'b1) : dv_q1[W]);

  always_comb begin
    lo_nxt     = '0;
    hi_nxt     = '0;
    st_out_nxt = qrs_status_t'(st_f);
    if (qrs_status_t'(st_f) == ST_OK) begin
      if (dbl_f) begin
        // double root: both fields carry the same quotient
        lo_nxt = val0;
        hi_nxt = val0;
        if (sat0) st_out_nxt = ST_SAT;
      end else begin
        if ($signed(val0) > $signed(val1)) begin
          lo_nxt = val1;
          hi_nxt = val0;
        end else begin
          lo_nxt = val0;
          hi_nxt = val1;
        end
        if (sat0 || sat1) st_out_nxt = ST_SAT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_r     <= lo_nxt;
      hi_r     <= hi_nxt;
      st_out_r <= st_out_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_root_low  = lo_r;
  assign out_root_high = hi_r;
  assign out_status    = st_out_r;

endmodule
`default_nettype wire

FILE: tb/sv/tb_quadratic_real_root_solver_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_quadratic_real_root_solver_top;
  import qrs_pkg::*;

  localparam int W = 32;
  localparam int FB = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [W-1:0] lo;
    logic [W-1:0] hi;
    qrs_status_t  st;
  } roots_t;

  // rounded quotient num/den, ties away from zero, clamped to the word range
  function automatic logic [W-1:0] quot_round(input logic neg, input logic [255:0] num,
                                              input logic [255:0] den, inout logic sat);
    logic [255:0] q;
    logic [255:0] lim;
    q = (2 * num + den) / (2 * den);
    lim = neg ? (256'd1 << (W - 1)) : (256'd1 << (W - 1)) - 1;
    if (q > lim) begin
      q = lim;
      sat = 1'b1;
    end
    return neg ? -q[W-1:0] : q[W-1:0];
  endfunction

  function automatic logic [255:0] isqrt(input logic [255:0] d);
    logic [255:0] r;
    logic [255:0] t;
    r = '0;
    for (int i = 127; i >= 0; i--) begin
      t = r | (256'd1 << i);
      if (t * t <= d) r = t;
    end
    return r;
  endfunction

  function automatic roots_t solve_quadratic(input logic signed [W-1:0] a,
                                             input logic signed [W-1:0] b,
                                             input logic signed [W-1:0] c);
    roots_t res;
    logic sa, sb, sc, sat, bpos;
    logic [255:0] ma, mb, mc, p, r, d, s, t;
    logic signed [W-1:0] r0, r1, tmp;
    sa = a[W-1];
    sb = b[W-1];
    sc = c[W-1];
    ma = {224'd0, sa ? -a : a};
    mb = {224'd0, sb ? -b : b};
    mc = {224'd0, sc ? -c : c};
    ma[W] = 1'b0; mb[W] = 1'b0; mc[W] = 1'b0;
    ma[W-1:0] = sa ? (~a + 1'b1) : a;
    mb[W-1:0] = sb ? (~b + 1'b1) : b;
    mc[W-1:0] = sc ? (~c + 1'b1) : c;
    res.lo = '0;
    res.hi = '0;
    sat = 1'b0;
    if (ma == 0) begin
      res.st = ST_AZERO;
      return res;
    end
    p = mb * mb;
    r = 4 * ma * mc;
    res.st = ST_OK;
    if (sa != sc && mc != 0) d = p + r;
    else if (p < r) begin
      res.st = ST_NOREAL;
      return res;
    end else d = p - r;
    if (d == 0) begin
      r0 = quot_round(mb != 0 && (!sb) != sa, mb << FB, ma << 1, sat);
      r1 = r0;
    end else begin
      bpos = !sb && mb != 0;
      s = isqrt(d);
      t = s + mb;
      r0 = quot_round(bpos != sa, t << FB, ma << 1, sat);
      r1 = quot_round((!sc && mc != 0) != !bpos, mc << (FB + 1), t, sat);
      if (r0 > r1) begin
        tmp = r0; r0 = r1; r1 = tmp;
      end
    end
    if (sat) res.st = ST_SAT;
    res.lo = r0;
    res.hi = r1;
    return res;
  endfunction

  class root_scoreboard;
    roots_t pending[$];
    int errors;
    int n_checked;
    int st_seen[4];

    function void note_coefs(logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] c);
      pending.push_back(solve_quadratic(a, b, c));
    endfunction

    function void check_roots(logic [W-1:0] lo, logic [W-1:0] hi, logic [1:0] st);
      roots_t e;
      if (pending.size() == 0) begin
        $error("unexpected result item: low %h high %h status %0d", lo, hi, st);
        errors++;
        return;
      end
      e = pending.pop_front();
      n_checked++;
      st_seen[e.st]++;
      if (lo !== e.lo) begin
        $error("root_low: expected %h, got %h", e.lo, lo);
        errors++;
      end
      if (hi !== e.hi) begin
        $error("root_high: expected %h, got %h", e.hi, hi);
        errors++;
      end
      if (st !== e.st) begin
        $error("status: expected %0d, got %0d", e.st, st);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [W-1:0] in_coef_a;
  logic signed [W-1:0] in_coef_b;
  logic signed [W-1:0] in_coef_c;
  logic out_valid;
  logic out_ready;
  logic signed [W-1:0] out_root_low;
  logic signed [W-1:0] out_root_high;
  logic [1:0] out_status;

  root_scoreboard sb;
  int tx_idle;
  int rx_idle;
  int cycles;

  quadratic_real_root_solver_top #(.WORD_WIDTH(W), .FRAC_BITS(FB)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_coef_a(in_coef_a), .in_coef_b(in_coef_b), .in_coef_c(in_coef_c),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_root_low(out_root_low), .out_root_high(out_root_high), .out_status(out_status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= rx_idle);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_roots(out_root_low, out_root_high, out_status);
  end

  // valid is only dropped while idling, so back-to-back items keep it high
  task automatic send_coefs(input logic [W-1:0] a, input logic [W-1:0] b,
                            input logic [W-1:0] c);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_coef_a <= a;
    in_coef_b <= b;
    in_coef_c <= c;
    do @(posedge clk); while (!in_ready);
    sb.note_coefs(a, b, c);
  endtask

  function automatic logic [W-1:0] rand_small();
    logic [W-1:0] v;
    v = $urandom_range(20 << FB);
    return $urandom_range(1) ? -v : v;
  endfunction

  task automatic send_random();
    int k, r1, r2, pick;
    pick = $urandom_range(9);
    if (pick < 3) begin
      send_coefs($urandom, $urandom, $urandom);
    end else if (pick < 6) begin
      send_coefs(rand_small(), rand_small(), rand_small());
    end else if (pick < 9) begin
      // integer roots, often repeated, so the discriminant is a perfect square or zero
      k = $urandom_range(1, 8);
      r1 = $signed($urandom_range(40)) - 20;
      r2 = $urandom_range(3) == 0 ? r1 : $signed($urandom_range(40)) - 20;
      if ($urandom_range(1)) k = -k;
      send_coefs(k << FB, (-k * (r1 + r2)) << FB, (k * r1 * r2) << FB);
    end else begin
      // tiny leading coefficient pushes roots out of range
      send_coefs($signed($urandom_range(8)) - 4, $urandom, rand_small());
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_coef_a = '0;
    in_coef_b = '0;
    in_coef_c = '0;
    out_ready = 1'b0;
    tx_idle = 0;
    rx_idle = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_coefs(0, 32'h0001_0000, 32'h0002_0000);
    send_coefs(0, 32'h8000_0000, 32'h7fff_ffff);
    send_coefs(32'h0001_0000, 0, 32'h0001_0000);
    send_coefs(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
    send_coefs(32'hffff_0000, 32'h0002_0000, 32'hffff_0000);
    send_coefs(32'h0001_0000, 0, 32'hfffc_0000);
    send_coefs(32'h0001_0000, 32'hfffd_0000, 32'h0002_0000);
    send_coefs(32'h0001_0000, 32'h0003_0000, 32'h0002_0000);
    send_coefs(32'h0001_0000, 32'h0001_0000, 0);
    send_coefs(32'h0002_0000, 0, 0);
    send_coefs(1, 32'h7fff_ffff, 1);
    send_coefs(1, 32'h8000_0000, 32'hffff_ffff);
    send_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_coefs(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    send_coefs(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_coefs(32'h8000_0000, 0, 32'h7fff_ffff);
    send_coefs(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_coefs(1, 0, 1);
    send_coefs(1, 2, 1);
    send_coefs(32'h0003_0000, 32'hfffb_0000, 32'hfffe_0000);

    tx_idle = 20; rx_idle = 63;
    repeat (570) send_random();
    tx_idle = 63; rx_idle = 20;
    repeat (570) send_random();
    tx_idle = 0; rx_idle = 0;
    repeat (570) send_random();
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2 * W + 20) @(posedge clk);

    $display("checked %0d result items: ok %0d, no real root %0d, a zero %0d, saturated %0d",
             sb.n_checked, sb.st_seen[ST_OK], sb.st_seen[ST_NOREAL],
             sb.st_seen[ST_AZERO], sb.st_seen[ST_SAT]);
    $display("idle mixes: sender-heavy, receiver-heavy and full rate");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
